### sv/tmqs_pkg.sv
`timescale 1ns / 1ps

package tmqs_pkg;

   // queue size default
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int SPEED_W  = 11;
   localparam int TURN_W   = 11;
   localparam int DUR_W    = 16;
   localparam int ENTRY_W  = SPEED_W + TURN_W + DUR_W;
   localparam int STATUS_W = 3;
   localparam int WHEEL_W  = 14;
   localparam int REQ_W    = 2;

   // wheel arithmetic: 18*s +/- 65*t, then divide magnitude by 18
   localparam int SUM_W       = 18;
   localparam int MAG_W       = SUM_W - 1;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   // ceil(2^22 / 18), exact for magnitudes below 2^17
   localparam logic [RECIP_W-1:0] RECIP_18 = RECIP_W'(233017);

   // request kinds
   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RESET   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_QUEUED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RESET   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_IDLE    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_MOTION  = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_STOPPED = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_LOAD,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE,
      ST_FINISH
   } state_type;

   // scaled product back to a signed wheel speed, truncated toward zero
   function automatic logic signed [WHEEL_W-1:0] wheel_from_prod(
      input logic [PROD_W-1:0] prod,
      input logic              neg
   );
      logic [WHEEL_W-1:0] mag;
      mag = WHEEL_W'(prod[PROD_W-1:RECIP_SHIFT]);
      return neg ? $signed(-mag) : $signed(mag);
   endfunction

endpackage

### sv/tmqs_ram.sv
`timescale 1ns / 1ps

module tmqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/timed_motion_queue_sequencer.sv
`timescale 1ns / 1ps
// Ring queue of timed motions driving two wheel speeds. Each request beat
// is handled alone: enqueue, pointer reset and unknown kinds go straight to
// the result load, a tick that does not move to a new motion reads the head
// entry first, and a tick that starts the next motion runs head entry read,
// next entry read, one shared multiplier pass for each wheel and result load.
// This follows from the single registered read port of the motion memory
// and the one reciprocal multiplier that is reused for the left and the
// right wheel. The result beat sits in an output register, so a request can
// be taken while it waits; a finished result holds in the final state only
// while an older one is still not taken. Entries carry flip-flop valid bits
// cleared by reset, so no memory clearing pass is needed after reset.
module timed_motion_queue_sequencer #(
   parameter int QUEUE_DEPTH = tmqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // speed[10:0], yaw_rate[21:11], duration[37:22]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // left_wheel[13:0], right_wheel[27:14]
   output logic [3:0]  rsp_tuser    // status[2:0], drive_update[3]
);

   import tmqs_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // request fields
   logic [REQ_W-1:0]          req_kind;
   logic signed [SPEED_W-1:0] req_speed;
   logic signed [TURN_W-1:0]  req_turn;
   logic [DUR_W-1:0]          req_dur;
   logic                      req_acc;

   assign req_kind  = req_tuser;
   assign req_speed = $signed(req_tdata[SPEED_W-1:0]);
   assign req_turn  = $signed(req_tdata[SPEED_W+TURN_W-1:SPEED_W]);
   assign req_dur   = req_tdata[ENTRY_W-1:SPEED_W+TURN_W];
   assign req_acc   = req_tvalid & req_tready;

   // state
   state_type state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [DUR_W-1:0]       elapsed_ff, elapsed_in;
   logic                   stopped_ff, stopped_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [SPEED_W-1:0] spd_ff, spd_in;
   logic signed [TURN_W-1:0]  trn_ff, trn_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic                      res_upd_ff, res_upd_in;
   logic signed [WHEEL_W-1:0] res_left_ff, res_left_in;
   logic signed [WHEEL_W-1:0] res_right_ff, res_right_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_upd_ff, rsp_upd_in;
   logic signed [WHEEL_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [WHEEL_W-1:0] rsp_right_ff, rsp_right_in;

   // memory port
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // derived values
   logic [IDX_W-1:0]          tail_next, head_next;
   logic                      queue_full, out_free;
   logic                      head_valid;
   logic [DUR_W-1:0]          head_dur, elapsed_inc;
   logic signed [SUM_W-1:0]   spd_x, trn_x, spd_18, trn_65, wheel_sum;
   logic [MAG_W-1:0]          wheel_mag;

   assign tail_next  = next_slot(tail_ff);
   assign head_next  = next_slot(head_ff);
   assign queue_full = (tail_next == head_ff);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign head_valid = valid_ff[head_ff];
   assign head_dur   = head_valid ? ram_rd_data[ENTRY_W-1:SPEED_W+TURN_W] : '0;
   assign elapsed_inc = (elapsed_ff == {DUR_W{1'b1}}) ? elapsed_ff : elapsed_ff + 1'b1;

   // shared wheel unit: left in ST_LEFT, right in ST_RIGHT
   assign spd_x     = SUM_W'(spd_ff);
   assign trn_x     = SUM_W'(trn_ff);
   assign spd_18    = (spd_x <<< 4) + (spd_x <<< 1);
   assign trn_65    = (trn_x <<< 6) + trn_x;
   assign wheel_sum = (state_ff == ST_RIGHT) ? spd_18 - trn_65 : spd_18 + trn_65;
   assign wheel_mag = wheel_sum[SUM_W-1] ? MAG_W'(-wheel_sum) : MAG_W'(wheel_sum);

   tmqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_kind == REQ_TICK) ? ST_TICK : ST_FINISH;
            end
         end
         ST_TICK: begin
            if (elapsed_inc >= head_dur && head_ff != tail_ff) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LOAD:   state_in = ST_LEFT;
         ST_LEFT:   state_in = ST_RIGHT;
         ST_RIGHT:  state_in = ST_DONE;
         ST_DONE:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      ram_rd_addr = (state_ff == ST_TICK) ? head_next : head_ff;
      ram_wr_en   = req_acc && (req_kind == REQ_ENQUEUE) && !queue_full;
      ram_wr_addr = tail_next;
      ram_wr_data = {req_dur, req_turn, req_speed};
   end

   // queue and datapath updates
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      elapsed_in    = elapsed_ff;
      stopped_in    = stopped_ff;
      valid_in      = valid_ff;
      spd_in        = spd_ff;
      trn_in        = trn_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      res_status_in = res_status_ff;
      res_upd_in    = res_upd_ff;
      res_left_in   = res_left_ff;
      res_right_in  = res_right_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_upd_in    = rsp_upd_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;

      unique case (state_ff)
         ST_IDLE: begin
            res_upd_in   = 1'b0;
            res_left_in  = '0;
            res_right_in = '0;
            if (req_acc) begin
               case (req_kind)
                  REQ_ENQUEUE: begin
                     if (queue_full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        tail_in             = tail_next;
                        valid_in[tail_next] = 1'b1;
                        res_status_in       = STAT_QUEUED;
                     end
                  end
                  REQ_RESET: begin
                     head_in       = '0;
                     tail_in       = '0;
                     res_status_in = STAT_RESET;
                  end
                  default: res_status_in = STAT_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            res_status_in = STAT_IDLE;
            if (elapsed_inc < head_dur) begin
               elapsed_in = elapsed_inc;
            end else begin
               elapsed_in = '0;
               if (head_ff == tail_ff) begin
                  // queue drained: stop once
                  if (!stopped_ff) begin
                     stopped_in        = 1'b1;
                     valid_in[head_ff] = 1'b0;
                     res_status_in     = STAT_STOPPED;
                     res_upd_in        = 1'b1;
                  end
               end else begin
                  // advance and retire the slot just left
                  valid_in[head_ff] = 1'b0;
                  head_in           = head_next;
                  stopped_in        = 1'b0;
               end
            end
         end
         ST_LOAD: begin
            spd_in = head_valid ? $signed(ram_rd_data[SPEED_W-1:0]) : '0;
            trn_in = head_valid ? $signed(ram_rd_data[SPEED_W+TURN_W-1:SPEED_W]) : '0;
         end
         ST_LEFT: begin
            prod_in = PROD_W'(wheel_mag) * PROD_W'(RECIP_18);
            neg_in  = wheel_sum[SUM_W-1];
         end
         ST_RIGHT: begin
            res_left_in = wheel_from_prod(prod_ff, neg_ff);
            prod_in     = PROD_W'(wheel_mag) * PROD_W'(RECIP_18);
            neg_in      = wheel_sum[SUM_W-1];
         end
         ST_DONE: begin
            res_right_in  = wheel_from_prod(prod_ff, neg_ff);
            res_status_in = STAT_MOTION;
            res_upd_in    = 1'b1;
         end
         ST_FINISH: begin
            // move the result into the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_upd_in    = res_upd_ff;
               rsp_left_in   = res_left_ff;
               rsp_right_in  = res_right_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         elapsed_ff   <= '0;
         stopped_ff   <= 1'b1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         elapsed_ff   <= elapsed_in;
         stopped_ff   <= stopped_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      spd_ff        <= spd_in;
      trn_ff        <= trn_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      res_status_ff <= res_status_in;
      res_upd_ff    <= res_upd_in;
      res_left_ff   <= res_left_in;
      res_right_ff  <= res_right_in;
      rsp_status_ff <= rsp_status_in;
      rsp_upd_ff    <= rsp_upd_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_right_ff, rsp_left_ff};
   assign rsp_tuser  = {rsp_upd_ff, rsp_status_ff};

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tmqs_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;

   // one result beat, unpacked from tuser and tdata
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      upd;
      logic signed [WHEEL_W-1:0] left;
      logic signed [WHEEL_W-1:0] right;
   } drive_beat_type;

   // tracks the motion queue and holds the drive beats still to come
   class motion_scoreboard;
      logic signed [SPEED_W-1:0] slot_speed [DEPTH];
      logic signed [TURN_W-1:0]  slot_turn [DEPTH];
      logic [DUR_W-1:0]          slot_dur [DEPTH];
      int unsigned               head;
      int unsigned               tail;
      logic [DUR_W-1:0]          elapsed;
      bit                        stopped;
      drive_beat_type            expected_drives[$];
      int                        errors;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            clear_slot(i);
         end
         head    = 0;
         tail    = 0;
         elapsed = '0;
         stopped = 1'b1;
         errors  = 0;
      endfunction

      function int unsigned next_slot(int unsigned i);
         return (i + 1 >= DEPTH) ? 0 : i + 1;
      endfunction

      function void clear_slot(int unsigned i);
         slot_speed[i] = '0;
         slot_turn[i]  = '0;
         slot_dur[i]   = '0;
      endfunction

      // advance the queue model by one accepted request beat
      function void note_request(logic [REQ_W-1:0] kind, logic [SPEED_W-1:0] spd,
                                 logic [TURN_W-1:0] trn, logic [DUR_W-1:0] dur);
         drive_beat_type res;
         int unsigned    nxt;
         int unsigned    prev;
         int             s;
         int             tr;
         res = '0;
         case (kind)
            REQ_ENQUEUE: begin
               nxt = next_slot(tail);
               if (nxt == head) begin
                  res.status = STAT_FULL;
               end else begin
                  tail            = nxt;
                  slot_speed[nxt] = spd;
                  slot_turn[nxt]  = trn;
                  slot_dur[nxt]   = dur;
                  res.status      = STAT_QUEUED;
               end
            end
            REQ_RESET: begin
               head       = 0;
               tail       = 0;
               res.status = STAT_RESET;
            end
            REQ_TICK: begin
               if (elapsed != '1) elapsed++;
               if (elapsed < slot_dur[head]) begin
                  res.status = STAT_IDLE;
               end else begin
                  elapsed = '0;
                  if (head == tail) begin
                     if (!stopped) begin
                        stopped = 1'b1;
                        clear_slot(head);
                        res.status = STAT_STOPPED;
                        res.upd    = 1'b1;
                     end else begin
                        res.status = STAT_IDLE;
                     end
                  end else begin
                     // next motion: wheel speeds from the new head entry
                     prev      = head;
                     head      = next_slot(head);
                     stopped   = 1'b0;
                     s         = slot_speed[head];
                     tr        = slot_turn[head];
                     res.left  = WHEEL_W'((18 * s + 65 * tr) / 18);
                     res.right = WHEEL_W'((18 * s - 65 * tr) / 18);
                     clear_slot(prev);
                     res.status = STAT_MOTION;
                     res.upd    = 1'b1;
                  end
               end
            end
            default: begin
               res.status = STAT_IDLE;
            end
         endcase
         expected_drives.push_back(res);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_drive(drive_beat_type got);
         drive_beat_type want;
         if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("result beat with none pending, status %0d",
                                      got.status));
            return;
         end
         want = expected_drives.pop_front();
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.upd != want.upd)
            report_mismatch($sformatf("drive_update %0d, want %0d", got.upd, want.upd));
         if (got.left != want.left)
            report_mismatch($sformatf("left_wheel %0d, want %0d", got.left, want.left));
         if (got.right != want.right)
            report_mismatch($sformatf("right_wheel %0d, want %0d", got.right, want.right));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // speed[10:0], yaw_rate[21:11], duration[37:22]
   logic [1:0]  req_tuser  = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // left_wheel[13:0], right_wheel[27:14]
   logic [3:0]  rsp_tuser;         // status[2:0], drive_update[3]

   bit               quiet = 1'b0;
   motion_scoreboard sb;

   timed_motion_queue_sequencer #(
      .QUEUE_DEPTH (DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // drive one request beat and wait until it is taken
   task automatic send_beat(input logic [REQ_W-1:0] kind, input logic [SPEED_W-1:0] spd,
                            input logic [TURN_W-1:0] trn, input logic [DUR_W-1:0] dur);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, dur, trn, spd};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, spd, trn, dur);
   endtask

   // result side: check taken beats, stall in random bursts
   initial begin
      drive_beat_type got;
      int             stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[2:0];
            got.upd    = rsp_tuser[3];
            got.left   = rsp_tdata[13:0];
            got.right  = rsp_tdata[27:14];
            sb.check_drive(got);
         end
         if (quiet) begin
            stall = 0;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // request side
   initial begin
      int unsigned               r;
      int unsigned               enq_pct;
      logic signed [SPEED_W-1:0] spd;
      logic signed [TURN_W-1:0]  trn;
      logic [DUR_W-1:0]          dur;
      bit                        force_reset;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty and stopped tick, unknown kind
      send_beat(REQ_TICK, '0, '0, '0);
      send_beat(REQ_NONE, SPEED_W'($urandom), TURN_W'($urandom), DUR_W'($urandom));
      // extreme speeds and turn rates, short durations
      send_beat(REQ_ENQUEUE, 11'h400, 11'h3FF, 16'd0);
      send_beat(REQ_ENQUEUE, 11'h3FF, 11'h400, 16'd1);
      send_beat(REQ_ENQUEUE, 11'sd1000, 11'sd1000, 16'd2);
      send_beat(REQ_ENQUEUE, -11'sd1000, -11'sd1000, 16'd0);
      // run through the motions, then stop
      repeat (6) send_beat(REQ_TICK, SPEED_W'($urandom), TURN_W'($urandom),
                           DUR_W'($urandom));
      // fill to full with any content, one more is dropped, then drop the lot
      send_beat(REQ_RESET, SPEED_W'($urandom), TURN_W'($urandom), DUR_W'($urandom));
      repeat (DEPTH - 1) send_beat(REQ_ENQUEUE, SPEED_W'($urandom), TURN_W'($urandom),
                                   DUR_W'($urandom));
      send_beat(REQ_ENQUEUE, SPEED_W'($urandom), TURN_W'($urandom), 16'hFFFF);
      send_beat(REQ_RESET, SPEED_W'($urandom), TURN_W'($urandom), DUR_W'($urandom));

      // random traffic in segments of varying enqueue pressure
      force_reset = 1'b0;
      enq_pct     = 35;
      for (int n = 0; n < 1900; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       enq_pct = 15;
               1:       enq_pct = 35;
               default: enq_pct = 60;
            endcase
         end
         if (n == 1700) quiet = 1'b1;
         if (n == 900) begin
            // drain everything before going on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.expected_drives.size() != 0);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         spd = SPEED_W'($urandom);
         trn = TURN_W'($urandom);
         dur = DUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                  : $urandom_range(0, 4));
         r   = $urandom_range(0, 99);
         if (force_reset) begin
            force_reset = 1'b0;
            send_beat(REQ_RESET, spd, trn, dur);
         end else if (r < 3) begin
            send_beat(REQ_RESET, spd, trn, dur);
         end else if (r < 6) begin
            send_beat(REQ_NONE, spd, trn, dur);
         end else if (r < 6 + enq_pct) begin
            // a long motion is discarded by a pointer reset right after it
            if (sb.next_slot(sb.tail) != 0 && $urandom_range(0, 49) == 0) begin
               dur         = DUR_W'($urandom);
               force_reset = 1'b1;
            end
            send_beat(REQ_ENQUEUE, spd, trn, dur);
         end else begin
            send_beat(REQ_TICK, spd, trn, dur);
         end
      end

      // wait out the remaining results
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_drives.size() != 0);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
